// ===== rtl/hcr_pkg.sv =====
// Package for the hi-res artifact colour renderer.
// Item, result and render-job types, row constants and the window colour table.
// No dependencies.
package hcr_pkg;

    localparam int COLUMNS          = 40;
    localparam int JOB_QUEUE_DEPTH  = 4;
    localparam int JQ_PTR_W         = $clog2(JOB_QUEUE_DEPTH);
    localparam int JQ_CNT_W         = $clog2(JOB_QUEUE_DEPTH + 1);
    localparam logic [5:0] LAST_COL = 6'(COLUMNS - 1);

    typedef struct packed {
        logic [7:0] main_byte;
        logic [7:0] aux_byte;
    } item_t;

    typedef struct packed {
        logic [5:0]  column_index;
        logic [55:0] pixel_colors;
        logic        end_of_row;
        logic        last_of_run;
    } result_t;

    typedef struct packed {
        logic [2:0]  ctx;
        logic [13:0] cur;
        logic [13:0] nxt;
        logic [5:0]  col;
        logic        phase;
        logic        end_of_row;
        logic        last_of_run;
    } job_t;

    typedef struct packed {
        logic valid;
        job_t job;
    } job_req_t;

    typedef struct packed {
        logic tail_valid;
        logic job_push;
    } front_status_t;

    localparam logic [7:0] WINDOW_COLOR [128] = '{
        8'h00, 8'h00, 8'h00, 8'h00, 8'h88, 8'h00, 8'hcc, 8'h00,
        8'h11, 8'h11, 8'h55, 8'h11, 8'h99, 8'h99, 8'hdd, 8'hff,
        8'h22, 8'h22, 8'h66, 8'h66, 8'haa, 8'haa, 8'hee, 8'hee,
        8'h33, 8'h33, 8'h33, 8'h33, 8'hbb, 8'hbb, 8'hff, 8'hff,
        8'h00, 8'h00, 8'h44, 8'h44, 8'hcc, 8'hcc, 8'hcc, 8'hcc,
        8'h55, 8'h55, 8'h55, 8'h55, 8'h99, 8'h99, 8'hdd, 8'hff,
        8'h66, 8'h22, 8'h66, 8'h66, 8'hee, 8'haa, 8'hee, 8'hee,
        8'h77, 8'h77, 8'h77, 8'h77, 8'hff, 8'hff, 8'hff, 8'hff,
        8'h00, 8'h00, 8'h00, 8'h00, 8'h88, 8'h88, 8'h88, 8'h88,
        8'h11, 8'h11, 8'h55, 8'h11, 8'h99, 8'h99, 8'hdd, 8'h99,
        8'h00, 8'h22, 8'h66, 8'h66, 8'haa, 8'haa, 8'haa, 8'haa,
        8'h33, 8'h33, 8'h33, 8'h33, 8'hbb, 8'hbb, 8'hff, 8'hff,
        8'h00, 8'h00, 8'h44, 8'h44, 8'hcc, 8'hcc, 8'hcc, 8'hcc,
        8'h11, 8'h11, 8'h55, 8'h55, 8'h99, 8'h99, 8'hdd, 8'hdd,
        8'h00, 8'h22, 8'h66, 8'h66, 8'hee, 8'haa, 8'hee, 8'hee,
        8'hff, 8'h33, 8'hff, 8'h77, 8'hff, 8'hff, 8'hff, 8'hff
    };

endpackage

// ===== rtl/hires_artifact_color_renderer.sv =====
// Hi-res artifact colour renderer, top level. Uses hcr_pkg, hcr_front, hcr_job_queue, hcr_back.
// Throughput: one column request per cycle while full is low; full is raised while the job queue
// is full and after the last column of a row, while its second job waits to enter the job queue.
// A column's job is issued when the next column is accepted and passes through the job queue
// and the registered result stage; the last column's own job is first registered as the row tail.
// Reset (rst_n, async, active low) clears row state, queues and mode (standard hi-res).
module hires_artifact_color_renderer
(
    input  logic             clk,
    input  logic             rst_n,
    input  logic             cfg_write_en,
    input  logic             cfg_write_data,
    input  logic             push,
    input  hcr_pkg::item_t   item,
    output logic             full,
    output logic             empty,
    input  logic             pop,
    output hcr_pkg::result_t result
);

    hcr_pkg::job_req_t     job_req;
    hcr_pkg::front_status_t status;
    hcr_pkg::job_t         q_job;
    logic                  q_full;
    logic                  q_valid;
    logic                  q_pop;

    hcr_front u_front
    (
        .clk            (clk),
        .rst_n          (rst_n),
        .cfg_write_en   (cfg_write_en),
        .cfg_write_data (cfg_write_data),
        .push           (push),
        .item           (item),
        .full           (full),
        .q_full         (q_full),
        .job_req        (job_req),
        .status         (status)
    );

    hcr_job_queue u_queue
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .wr_req   (job_req),
        .q_full   (q_full),
        .rd_pop   (q_pop),
        .rd_valid (q_valid),
        .rd_job   (q_job)
    );

    hcr_back u_back
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .job_valid (q_valid),
        .job       (q_job),
        .job_pop   (q_pop),
        .empty     (empty),
        .pop       (pop),
        .result    (result)
    );

    a_tail_blocks: assert property (@(posedge clk) disable iff (!rst_n)
        status.tail_valid |-> full)
        else $error("request taken while row tail job outstanding");

    a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
        status.job_push |-> !q_full)
        else $error("job issued into full queue");

    a_result_held: assert property (@(posedge clk) disable iff (!rst_n)
        !empty && !pop |=> !empty && $stable(result))
        else $error("waiting result changed or dropped");

    a_eor_last: assert property (@(posedge clk) disable iff (!rst_n)
        !empty && result.end_of_row |-> result.last_of_run)
        else $error("end of row result not last of run");

endmodule

// ===== rtl/hcr_front.sv =====
// Front end: accepts column requests, builds pixel groups, issues render jobs.
// Holds the mode register and row state. Depends on hcr_pkg.
module hcr_front
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  cfg_write_en,
    input  logic                  cfg_write_data,
    input  logic                  push,
    input  hcr_pkg::item_t        item,
    output logic                  full,
    input  logic                  q_full,
    output hcr_pkg::job_req_t     job_req,
    output hcr_pkg::front_status_t status
);

    logic        mode_reg;
    logic [5:0]  col_reg, col_next;
    logic [13:0] held_reg, held_next;
    logic [2:0]  ctx_reg, ctx_next;
    logic        carry_reg, carry_next;
    logic        pend_reg, pend_next;
    logic        tail_valid_reg, tail_valid_next;
    hcr_pkg::job_t tail_job_reg, tail_job_next;

    logic        accept;
    logic        is_last;
    logic [13:0] dbl;
    logic [13:0] grp;
    logic [2:0]  ctx_new;
    hcr_pkg::job_t job1;

    assign full    = tail_valid_reg || q_full;
    assign accept  = push && !full;
    assign is_last = (col_reg >= hcr_pkg::LAST_COL);
    assign ctx_new = pend_reg ? held_reg[13:11] : ctx_reg;

    always_comb
    begin
        for (int k = 0; k < 7; k++)
        begin
            dbl[2*k]   = item.main_byte[k];
            dbl[2*k+1] = item.main_byte[k];
        end
        if (mode_reg)
        begin
            grp = {item.main_byte[6:0], item.aux_byte[6:0]};
        end
        else if (item.main_byte[7])
        begin
            grp = {dbl[12:0], carry_reg};
        end
        else
        begin
            grp = dbl;
        end
    end

    always_comb
    begin
        job1.ctx         = ctx_reg;
        job1.cur         = held_reg;
        job1.nxt         = grp;
        job1.col         = col_reg - 6'd1;
        job1.phase       = mode_reg;
        job1.end_of_row  = 1'b0;
        job1.last_of_run = !is_last;
    end

    always_comb
    begin
        col_next        = col_reg;
        held_next       = held_reg;
        ctx_next        = ctx_reg;
        carry_next      = carry_reg;
        pend_next       = pend_reg;
        tail_valid_next = tail_valid_reg;
        tail_job_next   = tail_job_reg;

        if (tail_valid_reg && !q_full)
        begin
            tail_valid_next = 1'b0;
        end

        if (accept)
        begin
            if (is_last)
            begin
                tail_valid_next           = 1'b1;
                tail_job_next.ctx         = ctx_new;
                tail_job_next.cur         = grp;
                tail_job_next.nxt         = '0;
                tail_job_next.col         = col_reg;
                tail_job_next.phase       = mode_reg;
                tail_job_next.end_of_row  = 1'b1;
                tail_job_next.last_of_run = 1'b1;
                col_next   = '0;
                held_next  = '0;
                ctx_next   = '0;
                carry_next = 1'b0;
                pend_next  = 1'b0;
            end
            else
            begin
                col_next   = col_reg + 6'd1;
                held_next  = grp;
                ctx_next   = ctx_new;
                carry_next = grp[13];
                pend_next  = 1'b1;
            end
        end
    end

    always_comb
    begin
        job_req.valid = (accept && pend_reg) || (tail_valid_reg && !q_full);
        job_req.job   = tail_valid_reg ? tail_job_reg : job1;
    end

    assign status.tail_valid = tail_valid_reg;
    assign status.job_push   = job_req.valid;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mode_reg       <= 1'b0;
            col_reg        <= '0;
            held_reg       <= '0;
            ctx_reg        <= '0;
            carry_reg      <= 1'b0;
            pend_reg       <= 1'b0;
            tail_valid_reg <= 1'b0;
        end
        else
        begin
            if (cfg_write_en)
            begin
                mode_reg <= cfg_write_data;
            end
            col_reg        <= col_next;
            held_reg       <= held_next;
            ctx_reg        <= ctx_next;
            carry_reg      <= carry_next;
            pend_reg       <= pend_next;
            tail_valid_reg <= tail_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        tail_job_reg <= tail_job_next;
    end

endmodule

// ===== rtl/hcr_job_queue.sv =====
// Short job queue between front end and renderer.
// Register-based FIFO of render jobs. Depends on hcr_pkg.
module hcr_job_queue
(
    input  logic              clk,
    input  logic              rst_n,
    input  hcr_pkg::job_req_t wr_req,
    output logic              q_full,
    input  logic              rd_pop,
    output logic              rd_valid,
    output hcr_pkg::job_t     rd_job
);

    hcr_pkg::job_t entries_reg [hcr_pkg::JOB_QUEUE_DEPTH];
    logic [hcr_pkg::JQ_PTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [hcr_pkg::JQ_PTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [hcr_pkg::JQ_CNT_W-1:0] count_reg, count_next;
    logic do_wr, do_rd;

    assign q_full   = (count_reg == hcr_pkg::JQ_CNT_W'(hcr_pkg::JOB_QUEUE_DEPTH));
    assign rd_valid = (count_reg != '0);
    assign rd_job   = entries_reg[rd_ptr_reg];
    assign do_wr    = wr_req.valid && !q_full;
    assign do_rd    = rd_pop && rd_valid;

    always_comb
    begin
        wr_ptr_next = do_wr ? wr_ptr_reg + 1'b1 : wr_ptr_reg;
        rd_ptr_next = do_rd ? rd_ptr_reg + 1'b1 : rd_ptr_reg;
        count_next  = count_reg;
        if (do_wr && !do_rd)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (do_rd && !do_wr)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_wr)
        begin
            entries_reg[wr_ptr_reg] <= wr_req.job;
        end
    end

endmodule

// ===== rtl/hcr_back.sv =====
// Back end: renders one job per cycle, while the result stage is empty or popped, into 14 colour indices.
// Window table lookups with phase rotation, registered result stage. Depends on hcr_pkg.
module hcr_back
(
    input  logic             clk,
    input  logic             rst_n,
    input  logic             job_valid,
    input  hcr_pkg::job_t    job,
    output logic             job_pop,
    output logic             empty,
    input  logic             pop,
    output hcr_pkg::result_t result
);

    logic             out_valid_reg, out_valid_next;
    hcr_pkg::result_t out_reg;
    logic [55:0]      pix;
    logic             load;

    assign load    = job_valid && (!out_valid_reg || pop);
    assign job_pop = load;
    assign empty   = !out_valid_reg;
    assign result  = out_reg;

    always_comb
    begin
        logic [30:0] win;
        logic [1:0]  rot;
        logic [1:0]  sh;
        logic [7:0]  v;
        win = {job.nxt, job.cur, job.ctx};
        pix = '0;
        for (int b = 0; b < 14; b++)
        begin
            v   = hcr_pkg::WINDOW_COLOR[win[b +: 7]];
            rot = {job.col[0], 1'b0} + 2'(b) + {1'b0, job.phase};
            sh  = 2'd0 - rot;
            pix[4*b +: 4] = 4'(v >> sh);
        end
    end

    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (load)
        begin
            out_valid_next = 1'b1;
        end
        else if (pop)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else
        begin
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (load)
        begin
            out_reg.column_index <= job.col;
            out_reg.pixel_colors <= pix;
            out_reg.end_of_row   <= job.end_of_row;
            out_reg.last_of_run  <= job.last_of_run;
        end
    end

endmodule

// ===== tb/tb_hires_artifact_color_renderer.sv =====
`timescale 1ns / 100ps
// Testbench for hires_artifact_color_renderer: directed and random column requests.
// Holds its own colour predictor and checks every result; needs hcr_pkg and the RTL.
module tb_hires_artifact_color_renderer;

    typedef enum logic {MODE_STANDARD = 1'b0, MODE_DOUBLE = 1'b1} render_mode_e;
    typedef enum logic [1:0] {POP_ALWAYS, POP_HALF, POP_SPARSE, POP_PERIODIC} pop_style_e;

    localparam int SETTLE_CYCLES = 6;
    localparam int CYCLE_LIMIT   = 500000;
    localparam int RANDOM_ITEMS  = 2000;

    localparam logic [7:0] PATTERN_COLOUR [128] = '{
        8'h00, 8'h00, 8'h00, 8'h00, 8'h88, 8'h00, 8'hcc, 8'h00,
        8'h11, 8'h11, 8'h55, 8'h11, 8'h99, 8'h99, 8'hdd, 8'hff,
        8'h22, 8'h22, 8'h66, 8'h66, 8'haa, 8'haa, 8'hee, 8'hee,
        8'h33, 8'h33, 8'h33, 8'h33, 8'hbb, 8'hbb, 8'hff, 8'hff,
        8'h00, 8'h00, 8'h44, 8'h44, 8'hcc, 8'hcc, 8'hcc, 8'hcc,
        8'h55, 8'h55, 8'h55, 8'h55, 8'h99, 8'h99, 8'hdd, 8'hff,
        8'h66, 8'h22, 8'h66, 8'h66, 8'hee, 8'haa, 8'hee, 8'hee,
        8'h77, 8'h77, 8'h77, 8'h77, 8'hff, 8'hff, 8'hff, 8'hff,
        8'h00, 8'h00, 8'h00, 8'h00, 8'h88, 8'h88, 8'h88, 8'h88,
        8'h11, 8'h11, 8'h55, 8'h11, 8'h99, 8'h99, 8'hdd, 8'h99,
        8'h00, 8'h22, 8'h66, 8'h66, 8'haa, 8'haa, 8'haa, 8'haa,
        8'h33, 8'h33, 8'h33, 8'h33, 8'hbb, 8'hbb, 8'hff, 8'hff,
        8'h00, 8'h00, 8'h44, 8'h44, 8'hcc, 8'hcc, 8'hcc, 8'hcc,
        8'h11, 8'h11, 8'h55, 8'h55, 8'h99, 8'h99, 8'hdd, 8'hdd,
        8'h00, 8'h22, 8'h66, 8'h66, 8'hee, 8'haa, 8'hee, 8'hee,
        8'hff, 8'h33, 8'hff, 8'h77, 8'hff, 8'hff, 8'hff, 8'hff
    };

    logic             clk            = 1'b0;
    logic             rst_n          = 1'b0;
    logic             cfg_write_en   = 1'b0;
    logic             cfg_write_data = 1'b0;
    logic             push           = 1'b0;
    hcr_pkg::item_t   item           = '0;
    logic             full;
    logic             empty;
    logic             pop            = 1'b0;
    hcr_pkg::result_t result;

    // predictor state
    render_mode_e     cur_mode    = MODE_STANDARD;
    logic [5:0]       row_col     = '0;
    logic [13:0]      held_pixels = '0;
    logic [2:0]       lead_ctx    = '0;
    logic             carry_bit   = 1'b0;
    logic             held_valid  = 1'b0;
    hcr_pkg::result_t column_results [$];

    int         fail_count  = 0;
    int         cycle_count = 0;
    pop_style_e pop_style   = POP_ALWAYS;
    int         pop_left    = 0;

    hires_artifact_color_renderer dut
    (
        .clk            (clk),
        .rst_n          (rst_n),
        .cfg_write_en   (cfg_write_en),
        .cfg_write_data (cfg_write_data),
        .push           (push),
        .item           (item),
        .full           (full),
        .empty          (empty),
        .pop            (pop),
        .result         (result)
    );

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    function automatic logic [13:0] build_group(input logic [7:0] main_b, input logic [7:0] aux_b);
        logic [13:0] g;
        if (cur_mode == MODE_DOUBLE)
            return {main_b[6:0], aux_b[6:0]};
        for (int k = 0; k < 7; k++)
        begin
            g[2*k]   = main_b[k];
            g[2*k+1] = main_b[k];
        end
        if (main_b[7])
            g = {g[12:0], carry_bit};
        return g;
    endfunction

    function automatic logic [55:0] colour_group(input logic [2:0] ctx, input logic [13:0] cur,
                                                 input logic [13:0] nxt, input logic [5:0] col);
        logic [30:0] win;
        logic [55:0] pix;
        logic [7:0]  v;
        logic [1:0]  rot;
        logic [1:0]  sh;
        win = {nxt, cur, ctx};
        for (int b = 0; b < 14; b++)
        begin
            v   = PATTERN_COLOUR[win[b +: 7]];
            rot = 2'(int'(col) * 14 + b + int'(cur_mode));
            sh  = 2'd0 - rot;
            pix[4*b +: 4] = 4'(v >> sh);
        end
        return pix;
    endfunction

    task automatic predict_column(input hcr_pkg::item_t it);
        logic [5:0]       col;
        logic [13:0]      g;
        logic             row_end;
        hcr_pkg::result_t r;
        col     = row_col;
        g       = build_group(it.main_byte, it.aux_byte);
        row_end = (int'(col) >= hcr_pkg::COLUMNS - 1);
        if (held_valid)
        begin
            r.column_index = col - 6'd1;
            r.pixel_colors = colour_group(lead_ctx, held_pixels, g, col - 6'd1);
            r.end_of_row   = 1'b0;
            r.last_of_run  = !row_end;
            column_results.push_back(r);
            lead_ctx = held_pixels[13:11];
        end
        held_pixels = g;
        carry_bit   = g[13];
        held_valid  = 1'b1;
        if (row_end)
        begin
            r.column_index = col;
            r.pixel_colors = colour_group(lead_ctx, held_pixels, 14'd0, col);
            r.end_of_row   = 1'b1;
            r.last_of_run  = 1'b1;
            column_results.push_back(r);
            row_col     = '0;
            held_pixels = '0;
            lead_ctx    = '0;
            carry_bit   = 1'b0;
            held_valid  = 1'b0;
        end
        else
            row_col = col + 6'd1;
    endtask

    // predict on acceptance first, then check the popped result
    always @(posedge clk)
    begin
        hcr_pkg::result_t want;
        cycle_count++;
        if (cycle_count >= CYCLE_LIMIT)
        begin
            $display("%0t: timeout", $time);
            $display("tb_hires_artifact_color_renderer: done, errors");
            $finish;
        end
        if (rst_n)
        begin
            if (push && !full)
                predict_column(item);
            if (cfg_write_en)
                cur_mode = render_mode_e'(cfg_write_data);
            if (pop && !empty)
            begin
                if (column_results.size() == 0)
                begin
                    $display("%0t: unexpected result, expected none, actual %h", $time, result);
                    fail_count++;
                end
                else
                begin
                    want = column_results.pop_front();
                    if (result.column_index !== want.column_index)
                    begin
                        $display("%0t: column_index expected %0d actual %0d",
                                 $time, want.column_index, result.column_index);
                        fail_count++;
                    end
                    if (result.pixel_colors !== want.pixel_colors)
                    begin
                        $display("%0t: pixel_colors col %0d expected %h actual %h",
                                 $time, want.column_index, want.pixel_colors, result.pixel_colors);
                        fail_count++;
                    end
                    if (result.end_of_row !== want.end_of_row)
                    begin
                        $display("%0t: end_of_row col %0d expected %b actual %b",
                                 $time, want.column_index, want.end_of_row, result.end_of_row);
                        fail_count++;
                    end
                    if (result.last_of_run !== want.last_of_run)
                    begin
                        $display("%0t: last_of_run col %0d expected %b actual %b",
                                 $time, want.column_index, want.last_of_run, result.last_of_run);
                        fail_count++;
                    end
                end
            end
        end
    end

    // receiver stalls follow a style that is redrawn at random whenever its countdown runs out
    always @(negedge clk)
    begin
        if (!rst_n)
            pop <= 1'b0;
        else
        begin
            if (pop_left == 0)
            begin
                pop_style = pop_style_e'($urandom_range(0, 3));
                pop_left  = $urandom_range(50, 300);
            end
            else
                pop_left--;
            case (pop_style)
                POP_ALWAYS: pop <= 1'b1;
                POP_HALF:   pop <= 1'($urandom_range(0, 1));
                POP_SPARSE: pop <= ($urandom_range(0, 3) == 0);
                default:    pop <= ((cycle_count % 5) < 2);
            endcase
        end
    end

    function automatic hcr_pkg::item_t column(input logic [7:0] main_b, input logic [7:0] aux_b);
        hcr_pkg::item_t it;
        it.main_byte = main_b;
        it.aux_byte  = aux_b;
        return it;
    endfunction

    function automatic logic [7:0] pick_byte();
        logic [7:0] corner [10] = '{8'h00, 8'hff, 8'h7f, 8'h80, 8'h81, 8'hfe,
                                    8'h55, 8'haa, 8'hd5, 8'h40};
        if ($urandom_range(0, 9) < 3)
            return corner[$urandom_range(0, 9)];
        return 8'($urandom);
    endfunction

    task automatic send_column(input hcr_pkg::item_t it);
        push <= 1'b1;
        item <= it;
        @(posedge clk);
        while (full)
            @(posedge clk);
        @(negedge clk);
    endtask

    task automatic wait_idle();
        while (column_results.size() != 0)
            @(negedge clk);
        repeat (SETTLE_CYCLES) @(negedge clk);
    endtask

    task automatic write_mode(input render_mode_e m);
        wait_idle();
        cfg_write_en   <= 1'b1;
        cfg_write_data <= m;
        @(negedge clk);
        cfg_write_en   <= 1'b0;
    endtask

    // row start with delay flag, byte extremes, aux ignored in standard mode
    task automatic test_standard_extremes();
        send_column(column(8'h80, 8'h00));
        send_column(column(8'h00, 8'hff));
        send_column(column(8'hff, 8'hff));
        send_column(column(8'h7f, 8'h00));
        send_column(column(8'h80, 8'h7f));
        send_column(column(8'h81, 8'h80));
        send_column(column(8'h01, 8'h00));
        send_column(column(8'hfe, 8'h55));
        send_column(column(8'haa, 8'h00));
        send_column(column(8'hd5, 8'h00));
        push <= 1'b0;
    endtask

    // delay flag pulling in the previous group's last pixel
    task automatic test_delay_carry();
        send_column(column(8'h40, 8'h00));
        send_column(column(8'h80, 8'h00));
        send_column(column(8'hc0, 8'h00));
        send_column(column(8'h80, 8'h00));
        send_column(column(8'haa, 8'h00));
        push <= 1'b0;
    endtask

    // switch to double mode mid row; main bit 7 and aux bit 7 are ignored
    task automatic test_double_mode();
        write_mode(MODE_DOUBLE);
        send_column(column(8'h00, 8'h00));
        send_column(column(8'hff, 8'hff));
        send_column(column(8'h7f, 8'h80));
        send_column(column(8'h80, 8'h7f));
        send_column(column(8'h55, 8'haa));
        send_column(column(8'hc0, 8'h00));
        push <= 1'b0;
    endtask

    // back to standard: carry comes from the double-mode group
    task automatic test_mode_back();
        write_mode(MODE_STANDARD);
        send_column(column(8'h80, 8'h00));
        send_column(column(8'h2a, 8'hff));
        push <= 1'b0;
    endtask

    // random bursts over many rows; mode rewritten between chunks
    task automatic test_random_rows();
        int sent;
        int chunk;
        int burst;
        int gap;
        sent  = 0;
        burst = 0;
        while (sent < RANDOM_ITEMS)
        begin
            chunk = $urandom_range(1, 150);
            for (int i = 0; i < chunk; i++)
            begin
                if (burst == 0)
                begin
                    burst = $urandom_range(1, ($urandom_range(0, 3) == 0) ? 120 : 20);
                    gap   = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 12);
                    if (gap != 0)
                    begin
                        push <= 1'b0;
                        repeat (gap) @(negedge clk);
                    end
                end
                send_column(column(pick_byte(), pick_byte()));
                burst--;
            end
            push <= 1'b0;
            burst = 0;
            sent += chunk;
            write_mode(render_mode_e'($urandom_range(0, 1)));
        end
    endtask

    initial
    begin
        repeat (3) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);
        test_standard_extremes();
        test_delay_carry();
        test_double_mode();
        test_mode_back();
        test_random_rows();
        wait_idle();
        if (column_results.size() != 0)
            fail_count++;
        if (fail_count == 0)
            $display("tb_hires_artifact_color_renderer: done, clean");
        else
            $display("tb_hires_artifact_color_renderer: done, errors");
        $finish;
    end

endmodule
